### rtl/core/mpps_pkg.sv
// ----------------------------------------------------------------------------
// mpps_pkg
// shared types and constants for the multi-policy process scheduler
// ----------------------------------------------------------------------------
package mpps_pkg;

	typedef enum logic [1:0] {
		CMD_REGISTER   = 2'd0,
		CMD_UNREGISTER = 2'd1,
		CMD_SET_READY  = 2'd2,
		CMD_SCHEDULE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		POL_RR       = 2'd0,
		POL_FCFS     = 2'd1,
		POL_SJF      = 2'd2,
		POL_PRIORITY = 2'd3
	} policy_t;

	localparam logic [19:0] SJF_UNKNOWN = 20'd999999;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [15:0]        pid;
		logic               ready_flag;
		logic signed [15:0] prio_in;
		logic [15:0]        burst_in;
		logic [31:0]        arrival_in;
	} in_item_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] chosen_pid;
		logic [4:0]  entries_used;
		logic [31:0] switch_total;
	} out_item_t;

	// one table entry
	typedef struct packed {
		logic [15:0]        pid;
		logic               rdy;
		logic signed [15:0] prio;
		logic [15:0]        burst;
		logic [31:0]        arrival;
	} entry_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_item;   // capture input transaction
		logic scan_start;  // reset scan position and best
		logic scan_step;   // compare one entry, advance
		logic do_append;   // write new entry at count
		logic do_setrdy;   // write ready bit at found index
		logic shift_start; // start compaction at found index
		logic shift_step;  // move one entry down
		logic finish_unreg;
		logic finish_sched;
		logic finish_fail;
		logic finish_ok;
	} ctl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic scan_done;
		logic found;
		logic shift_done;
		logic full;
	} ctl_sts_t;

endpackage

### rtl/core/mpps_ctrl.sv
// ----------------------------------------------------------------------------
// mpps_ctrl
// command sequencer: runs lookup, selection and compaction walks
// ----------------------------------------------------------------------------
module mpps_ctrl import mpps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic [1:0] in_cmd,
	output logic     out_valid,
	input  logic     out_ready,
	output ctl_cmd_t ctl,
	input  ctl_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_SCAN, S_SHIFT, S_DONE
	} state_t;

	state_t     state_q;
	logic [1:0] cmd_q;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// command strobes
	always_comb begin
		ctl = '0;
		ctl.load_item = in_valid && in_ready;
		case (state_q)
			S_DECODE: begin
				case (cmd_q)
					CMD_REGISTER: begin
						ctl.do_append = !sts.full;
						ctl.finish_ok = !sts.full;
						ctl.finish_fail = sts.full;
					end
					default: ctl.scan_start = 1'b1;
				endcase
			end
			S_SCAN: begin
				ctl.scan_step = !sts.scan_done;
				if (sts.scan_done) begin
					case (cmd_q)
						CMD_UNREGISTER: begin
							ctl.shift_start = sts.found;
							ctl.finish_fail = !sts.found;
						end
						CMD_SET_READY: begin
							ctl.do_setrdy   = sts.found;
							ctl.finish_ok   = sts.found;
							ctl.finish_fail = !sts.found;
						end
						default: begin
							ctl.finish_sched = sts.found;
							ctl.finish_fail  = !sts.found;
						end
					endcase
				end
			end
			S_SHIFT: begin
				ctl.shift_step   = !sts.shift_done;
				ctl.finish_unreg = sts.shift_done;
			end
			default: ;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= CMD_REGISTER;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					cmd_q   <= in_cmd;
					state_q <= S_DECODE;
				end
				S_DECODE: state_q <= (cmd_q == CMD_REGISTER) ? S_DONE : S_SCAN;
				S_SCAN: if (sts.scan_done)
					state_q <= (cmd_q == CMD_UNREGISTER && sts.found) ? S_SHIFT : S_DONE;
				S_SHIFT: if (sts.shift_done) state_q <= S_DONE;
				S_DONE: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/mpps_dpath.sv
// ----------------------------------------------------------------------------
// mpps_dpath
// entry table, scan comparator, compaction and counters
// ----------------------------------------------------------------------------
module mpps_dpath import mpps_pkg::*; #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_item,
	input  logic [1:0] policy,
	input  ctl_cmd_t  ctl,
	output ctl_sts_t  sts,
	output out_item_t out_item
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	entry_t        table_q [MAX_ENTRIES];
	in_item_t      item_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] cursor_q;
	logic [31:0]   switch_q;
	logic [CW-1:0] pos_q;      // scan step number
	logic [IW-1:0] idx_q;      // physical index being scanned or shifted
	logic          found_q;
	logic [IW-1:0] best_q;
	out_item_t     res_q;

	entry_t        cur, bst;
	logic [19:0]   key_c, key_b;
	logic          better, hit;
	logic [IW-1:0] idx_next;
	logic [CW-1:0] cnt_m1;

	assign cur    = table_q[idx_q];
	assign bst    = table_q[best_q];
	assign key_c  = (cur.burst == '0) ? SJF_UNKNOWN : {4'd0, cur.burst};
	assign key_b  = (bst.burst == '0) ? SJF_UNKNOWN : {4'd0, bst.burst};
	assign cnt_m1 = count_q - 1'b1;
	assign idx_next = ({1'b0, idx_q} + 1'b1 >= {1'b0, count_q})
		? '0 : IW'(idx_q + 1'b1);

	// per-entry decision for the current scan step
	always_comb begin
		better = 1'b0;
		case (policy_t'(policy))
			POL_FCFS: better = cur.arrival < bst.arrival;
			POL_SJF: better = key_c < key_b ||
				(key_c == key_b && cur.arrival < bst.arrival);
			POL_PRIORITY: better = cur.prio > bst.prio ||
				(cur.prio == bst.prio && cur.arrival < bst.arrival);
			default: better = 1'b0;
		endcase
		if (item_q.cmd == CMD_SCHEDULE)
			hit = cur.rdy && (!found_q || (policy != POL_RR && better));
		else
			hit = !found_q && cur.pid == item_q.pid;
	end

	assign sts.scan_done  = (pos_q >= count_q) ||
		(found_q && (item_q.cmd != CMD_SCHEDULE || policy == POL_RR));
	assign sts.found      = found_q;
	assign sts.shift_done = ({1'b0, idx_q} + 1'b1 >= {1'b0, count_q});
	assign sts.full       = (count_q >= CW'(MAX_ENTRIES));
	assign out_item       = res_q;

	// table writes
	always_ff @(posedge clk) begin
		if (ctl.load_item) item_q <= in_item;
		if (ctl.do_append) begin
			table_q[count_q[IW-1:0]] <= '{pid: item_q.pid, rdy: 1'b1,
				prio: item_q.prio_in, burst: item_q.burst_in,
				arrival: item_q.arrival_in};
		end
		if (ctl.do_setrdy) table_q[best_q].rdy <= item_q.ready_flag;
		if (ctl.shift_step) table_q[idx_q] <= table_q[idx_next];
	end

	// scan and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
			switch_q <= '0;
			pos_q    <= '0;
			idx_q    <= '0;
			found_q  <= 1'b0;
			best_q   <= '0;
		end else begin
			if (ctl.scan_start) begin
				pos_q   <= '0;
				found_q <= 1'b0;
				best_q  <= '0;
				// cursor never exceeds the count, so one subtract wraps it
				if (item_q.cmd == CMD_SCHEDULE && policy == POL_RR &&
						{1'b0, cursor_q} >= count_q)
					idx_q <= IW'({1'b0, cursor_q} - count_q);
				else if (item_q.cmd == CMD_SCHEDULE && policy == POL_RR)
					idx_q <= cursor_q;
				else
					idx_q <= '0;
			end
			if (ctl.scan_step) begin
				pos_q <= pos_q + 1'b1;
				if (hit) begin
					found_q <= 1'b1;
					best_q  <= idx_q;
				end
				if (!(hit && (item_q.cmd != CMD_SCHEDULE || policy == POL_RR)))
					idx_q <= idx_next;
			end
			if (ctl.do_append) count_q <= count_q + 1'b1;
			if (ctl.shift_start) idx_q <= best_q;
			if (ctl.shift_step) idx_q <= IW'(idx_q + 1'b1);
			if (ctl.finish_unreg) begin
				count_q <= cnt_m1;
				if (cnt_m1 != '0 && {1'b0, cursor_q} >= cnt_m1)
					cursor_q <= IW'({1'b0, cursor_q} - cnt_m1);
			end
			if (ctl.finish_sched) begin
				switch_q <= switch_q + 1'b1;
				if (policy == POL_RR)
					cursor_q <= IW'(({1'b0, best_q} + 1'b1 >= {1'b0, count_q})
						? '0 : best_q + 1'b1);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.finish_ok || ctl.finish_fail || ctl.finish_unreg || ctl.finish_sched) begin
			res_q.ok           <= !ctl.finish_fail;
			res_q.chosen_pid   <= ctl.finish_sched ? bst.pid : 16'd0;
			res_q.entries_used <= 5'(ctl.finish_unreg ? cnt_m1
				: (ctl.do_append ? count_q + 1'b1 : count_q));
			res_q.switch_total <= ctl.finish_sched ? switch_q + 1'b1 : switch_q;
		end
	end

endmodule

### rtl/core/multi_policy_process_scheduler.sv
// ----------------------------------------------------------------------------
// multi_policy_process_scheduler
// process table with round robin, fcfs, sjf and priority selection
// ----------------------------------------------------------------------------
// latency to output valid: register passes decode and done; lookup and schedule pass decode, scan and done
// unregister adds compaction after a successful lookup scan, one entry moved a cycle
// one transaction at a time: next input taken in idle once no result waits for the receiver
// the scan over the table, one entry a cycle, sets the rate
// reset clears count, cursor, switch counter and policy; table contents undefined
module multi_policy_process_scheduler import mpps_pkg::*; #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [1:0] cfg_data
);

	ctl_cmd_t   ctl;
	ctl_sts_t   sts;
	logic [1:0] policy_q;

	// policy register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) policy_q <= POL_RR;
		else if (cfg_valid) policy_q <= cfg_data;
	end

	mpps_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_cmd(in_data.cmd),
		.out_valid, .out_ready, .ctl, .sts
	);

	mpps_dpath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dpath (
		.clk, .arst_n, .in_item(in_data), .policy(policy_q), .ctl, .sts,
		.out_item(out_data)
	);

	// only one finish strobe at once, no input accepted while scanning, reported count within capacity
	a_one_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({ctl.finish_ok, ctl.finish_fail, ctl.finish_unreg,
			ctl.finish_sched}) <= 1)
		else $error("multiple finish strobes");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan_step |-> !in_ready)
		else $error("input ready while scanning");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.entries_used <= 5'(MAX_ENTRIES))
		else $error("entry count beyond capacity");

endmodule

### tb/sv/tb_multi_policy_process_scheduler.sv
// ----------------------------------------------------------------------------
// tb_multi_policy_process_scheduler
// self-checking bench: table commands under all four policies, with an
// in-bench model of the process table predicting every response
// ----------------------------------------------------------------------------
module tb_multi_policy_process_scheduler;
	import mpps_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXE = 16;
	localparam int WATCHDOG = 20000;
	localparam int HOLD_CYCLES = 300;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [1:0] cfg_data;

	multi_policy_process_scheduler #(.MAX_ENTRIES(MAXE)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// process table shadow
	entry_t      shadow_tab[MAXE];
	int unsigned shadow_cnt;
	int unsigned shadow_cursor;
	logic [31:0] shadow_switches;
	policy_t     shadow_policy;

	in_item_t  cmd_queue[$];
	out_item_t resp_queue[$];
	int        errors;
	int        n_resp;
	int        n_picks;
	int        idle_cycles;
	bit        hold_off_req;
	bit        cfg_req;
	logic [1:0] cfg_req_val;
	logic [15:0] live_pids[$];

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int find_pid(logic [15:0] p);
		for (int i = 0; i < shadow_cnt; i++)
			if (shadow_tab[i].pid == p) return i;
		return -1;
	endfunction

	function automatic logic [19:0] job_len(int i);
		return (shadow_tab[i].burst == 0) ? SJF_UNKNOWN : {4'd0, shadow_tab[i].burst};
	endfunction

	function automatic int pick_entry();
		int best;
		bit better;
		int unsigned idx;
		best = -1;
		if (shadow_cnt == 0) return -1;
		if (shadow_policy == POL_RR) begin
			for (int i = 0; i < shadow_cnt; i++) begin
				idx = (shadow_cursor + i) % shadow_cnt;
				if (shadow_tab[idx].rdy) begin
					shadow_cursor = (idx + 1) % shadow_cnt;
					return idx;
				end
			end
			return -1;
		end
		for (int i = 0; i < shadow_cnt; i++) begin
			if (!shadow_tab[i].rdy) continue;
			if (best < 0) begin
				best = i;
				continue;
			end
			case (shadow_policy)
				POL_FCFS: better = shadow_tab[i].arrival < shadow_tab[best].arrival;
				POL_SJF: better = job_len(i) < job_len(best) ||
					(job_len(i) == job_len(best) &&
					shadow_tab[i].arrival < shadow_tab[best].arrival);
				default: better = shadow_tab[i].prio > shadow_tab[best].prio ||
					(shadow_tab[i].prio == shadow_tab[best].prio &&
					shadow_tab[i].arrival < shadow_tab[best].arrival);
			endcase
			if (better) best = i;
		end
		return best;
	endfunction

	// compute response of one accepted transaction
	function automatic out_item_t predict_response(in_item_t it);
		out_item_t r;
		int k;
		r = '0;
		case (cmd_t'(it.cmd))
			CMD_REGISTER: if (shadow_cnt < MAXE) begin
				shadow_tab[shadow_cnt] = '{it.pid, 1'b1, it.prio_in, it.burst_in, it.arrival_in};
				shadow_cnt++;
				r.ok = 1'b1;
			end
			CMD_UNREGISTER: begin
				k = find_pid(it.pid);
				if (k >= 0) begin
					for (int i = k; i + 1 < shadow_cnt; i++) shadow_tab[i] = shadow_tab[i + 1];
					shadow_cnt--;
					if (shadow_cnt > 0 && shadow_cursor >= shadow_cnt)
						shadow_cursor = shadow_cursor % shadow_cnt;
					r.ok = 1'b1;
				end
			end
			CMD_SET_READY: begin
				k = find_pid(it.pid);
				if (k >= 0) begin
					shadow_tab[k].rdy = it.ready_flag;
					r.ok = 1'b1;
				end
			end
			default: begin
				k = pick_entry();
				if (k >= 0) begin
					shadow_switches++;
					r.chosen_pid = shadow_tab[k].pid;
					r.ok = 1'b1;
				end
			end
		endcase
		r.entries_used = shadow_cnt[4:0];
		r.switch_total = shadow_switches;
		return r;
	endfunction

	function automatic in_item_t make_cmd(cmd_t c, logic [15:0] p, logic rf,
			logic [15:0] pr, logic [15:0] b, logic [31:0] a);
		in_item_t it;
		it.cmd = c;
		it.pid = p;
		it.ready_flag = rf;
		it.prio_in = pr;
		it.burst_in = b;
		it.arrival_in = a;
		return it;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// random command, mostly aimed at pids from earlier register commands
	function automatic in_item_t rand_cmd();
		int r;
		logic [15:0] p;
		r = $urandom_range(0, 99);
		if (live_pids.size() > 0 && $urandom_range(0, 3) != 0)
			p = live_pids[$urandom_range(0, live_pids.size() - 1)];
		else if ($urandom_range(0, 1))
			p = 16'($urandom_range(0, 7));
		else
			p = 16'($urandom);
		if (r < 30) begin
			if (live_pids.size() < 40) live_pids.push_back(p);
			return make_cmd(CMD_REGISTER, p, 1'($urandom), 16'($urandom),
				($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(0, 20)),
				($urandom_range(0, 1)) ? 32'($urandom_range(0, 15)) : 32'($urandom));
		end
		if (r < 45) return make_cmd(CMD_UNREGISTER, p, 1'($urandom), 16'($urandom),
			16'($urandom), $urandom);
		if (r < 65) return make_cmd(CMD_SET_READY, p, 1'($urandom), 16'($urandom),
			16'($urandom), $urandom);
		return make_cmd(CMD_SCHEDULE, p, 1'($urandom), 16'($urandom),
			16'($urandom), $urandom);
	endfunction

	// input driver
	int in_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			in_gap   <= 0;
		end else if (in_valid && !in_ready) begin
		end else if (in_gap > 0) begin
			in_valid <= 1'b0;
			in_gap   <= in_gap - 1;
		end else if (cmd_queue.size() > 0) begin
			in_valid <= 1'b1;
			in_data  <= cmd_queue.pop_front();
			in_gap   <= gap_len();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// prediction on input acceptance
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			resp_queue.push_back(predict_response(in_data));
	end

	// receiver backpressure, long hold counted here
	int out_stall;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
		end else if (hold_off_req) begin
			out_ready <= 1'b0;
			out_stall <= HOLD_CYCLES;
		end else if (out_stall > 0) begin
			out_ready <= 1'b0;
			out_stall <= out_stall - 1;
		end else begin
			out_ready <= 1'b1;
			if (out_valid && out_ready) out_stall <= gap_len();
		end
	end

	// response monitor
	out_item_t exp_r;
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_resp <= n_resp + 1;
			if (resp_queue.size() == 0) begin
				errors <= errors + 1;
				$display("%0t unexpected response %p", $time, out_data);
			end else begin
				exp_r = resp_queue.pop_front();
				if (exp_r.ok) n_picks <= n_picks + 1;
				if (exp_r.ok !== out_data.ok || exp_r.chosen_pid !== out_data.chosen_pid ||
						exp_r.entries_used !== out_data.entries_used ||
						exp_r.switch_total !== out_data.switch_total) begin
					errors <= errors + 1;
					$display("%0t mismatch: expected %p actual %p", $time, exp_r, out_data);
				end
			end
		end
	end

	// config channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid     <= 1'b0;
			cfg_data      <= '0;
			shadow_policy <= POL_RR;
		end else if (cfg_valid && cfg_ready) begin
			cfg_valid <= 1'b0;
			shadow_policy <= policy_t'(cfg_data);
		end else if (!cfg_valid && cfg_req) begin
			cfg_valid <= 1'b1;
			cfg_data  <= cfg_req_val;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic wait_drain();
		while (cmd_queue.size() > 0 || in_valid || resp_queue.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_policy(policy_t p);
		cfg_req_val = p;
		cfg_req = 1'b1;
		@(posedge clk);
		while (!(cfg_valid && cfg_ready)) @(posedge clk);
		cfg_req = 1'b0;
		@(posedge clk);
	endtask

	initial begin
		policy_t pols[5];
		pols = '{POL_FCFS, POL_SJF, POL_PRIORITY, POL_RR, POL_PRIORITY};
		arst_n = 1'b0;
		hold_off_req = 1'b0;
		cfg_req = 1'b0;
		cfg_req_val = '0;
		shadow_cnt = 0;
		shadow_cursor = 0;
		shadow_switches = '0;
		foreach (shadow_tab[i]) shadow_tab[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty schedule, absent pids, fill past full, extremes
		cmd_queue.push_back(make_cmd(CMD_SCHEDULE, 16'd0, 1'b0, 16'd0, 16'd0, 32'd0));
		cmd_queue.push_back(make_cmd(CMD_UNREGISTER, 16'hFFFF, 1'b1, 16'h7FFF, 16'd0, 32'd0));
		cmd_queue.push_back(make_cmd(CMD_SET_READY, 16'd5, 1'b1, 16'd0, 16'd0, 32'd0));
		for (int i = 0; i < 17; i++)
			cmd_queue.push_back(make_cmd(CMD_REGISTER, (i == 0) ? 16'hFFFF : 16'(i % 9),
				1'b0, (i % 2) ? 16'h8000 : 16'h7FFF, (i % 3 == 0) ? 16'd0 : 16'hFFFF,
				(i % 4 == 0) ? 32'hFFFFFFFF : 32'(i / 2)));
		cmd_queue.push_back(make_cmd(CMD_SET_READY, 16'd1, 1'b0, 16'd0, 16'd0, 32'd0));
		cmd_queue.push_back(make_cmd(CMD_SCHEDULE, 16'd0, 1'b0, 16'd0, 16'd0, 32'd0));
		cmd_queue.push_back(make_cmd(CMD_UNREGISTER, 16'd1, 1'b0, 16'd0, 16'd0, 32'd0));
		cmd_queue.push_back(make_cmd(CMD_SCHEDULE, 16'd0, 1'b0, 16'd0, 16'd0, 32'd0));
		wait_drain();

		// long receiver stall with the sender still offering transactions
		hold_off_req = 1'b1;
		for (int i = 0; i < 12; i++) cmd_queue.push_back(rand_cmd());
		repeat (2) @(posedge clk);
		hold_off_req = 1'b0;
		wait_drain();

		// random phases across policies
		for (int ph = 0; ph < 5; ph++) begin
			write_policy(pols[ph]);
			for (int i = 0; i < 135; i++) cmd_queue.push_back(rand_cmd());
			wait_drain();
		end

		$display("covered %0d responses, %0d successful, all four policies incl. full table",
			n_resp, n_picks);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### sim.f
rtl/core/mpps_pkg.sv
rtl/core/mpps_ctrl.sv
rtl/core/mpps_dpath.sv
rtl/core/multi_policy_process_scheduler.sv
tb/sv/tb_multi_policy_process_scheduler.sv
